// ===== sv/sequence_indexed_retransmit_buffer_macros.svh =====
// assertion macros for the sequence indexed retransmit buffer
// used by the top level only, no other dependencies
`ifndef SEQUENCE_INDEXED_RETRANSMIT_BUFFER_MACROS_SVH
`define SEQUENCE_INDEXED_RETRANSMIT_BUFFER_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SIRB_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// expression must never be true outside reset
`define SIRB_NEVER(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);
`else
`define SIRB_ASSERT(lbl, ck, rn, prop, msg)
`define SIRB_NEVER(lbl, ck, rn, expr, msg)
`endif
`endif

// ===== sv/sirb_pkg.sv =====
// shared constants for the sequence indexed retransmit buffer
// no dependencies; imported by the top level, the checker and the testbench
package sirb_pkg;
	localparam int MAX_SLOTS      = 256;
	localparam int MAX_SLOT_BYTES = 64;
	localparam int SLOT_W  = $clog2(MAX_SLOTS);
	localparam int BYTE_W  = $clog2(MAX_SLOT_BYTES);
	localparam int REC_AW  = SLOT_W + BYTE_W;
	localparam int SEQ_W   = 64;
	localparam int DIV_CW  = $clog2(SEQ_W);
	localparam int LEN_W   = 7;
	localparam int SIZE_W  = 7;
	localparam int CNT_W   = 9;
	localparam int CAP_W   = 16;
	localparam int IN_W    = 88;
	localparam int OUT_W   = 224;

	// commands
	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_RESUME = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_NOT_YET   = 3'd2;
	localparam logic [2:0] ST_EVICTED   = 3'd3;
	localparam logic [2:0] ST_NOT_EMPTY = 3'd4;

	// register indexes
	localparam logic REG_SLOT_SIZE  = 1'b0;
	localparam logic REG_SLOT_COUNT = 1'b1;
endpackage

// ===== sv/sequence_indexed_retransmit_buffer.sv =====
// sequence indexed retransmit buffer: record store, window counters, modulo sequencer
// depends on sirb_pkg and sequence_indexed_retransmit_buffer_macros.svh
//
// channel | dir | handshake        | contents
// s_*     | in  | s_tvalid/tready  | tuser {byte_valid,cmd}, tlast last_byte, tdata byte/seq/capacity
// m_*     | out | m_tvalid/tready  | tuser status, tlast last, tdata seq/byte/len/held/full/next/oldest
// wr_*    | in  | wr_en            | register index and value, no wait
//
// push byte without end: stores the byte. push end: decode, modulo of the 64-bit next sequence, copy, finish.
// get: window check, modulo of the 64-bit sequence, length fetch and capacity check, then per byte
// a memory read, output load and transfer. resume: empty check and window reload. the modulo is a
// restoring divider giving one quotient bit a cycle. reset clears counters and control only; the
// stores need no clearing pass. one transaction at a time: s_tready drops until the last result is taken.
`include "sequence_indexed_retransmit_buffer_macros.svh"
module sequence_indexed_retransmit_buffer
	import sirb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [CNT_W-1:0] wr_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // data_byte, seq_number, out_capacity
	input  logic [2:0]       s_tuser,   // cmd, byte_valid
	input  logic             s_tlast,   // last_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // seq_out, data_byte_out, record_length, held_count,
	                                    // full_res, next_seq_out, oldest_seq_out, zero fill
	output logic [2:0]       m_tuser,   // status
	output logic             m_tlast    // last
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PDEC  = 4'd1;
	localparam logic [3:0] S_MOD   = 4'd2;
	localparam logic [3:0] S_PCOPY = 4'd3;
	localparam logic [3:0] S_PFIN  = 4'd4;
	localparam logic [3:0] S_GCHK  = 4'd5;
	localparam logic [3:0] S_GLEN  = 4'd6;
	localparam logic [3:0] S_GCAP  = 4'd7;
	localparam logic [3:0] S_GRD   = 4'd8;
	localparam logic [3:0] S_GWR   = 4'd9;
	localparam logic [3:0] S_RES   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	// memories
	logic [7:0]       staging_mem [MAX_SLOT_BYTES];
	logic [7:0]       record_mem  [MAX_SLOTS*MAX_SLOT_BYTES];
	logic [LEN_W-1:0] length_mem  [MAX_SLOTS];

	logic [3:0]        state_q;
	logic [SIZE_W-1:0] slot_size_q;
	logic [CNT_W-1:0]  slot_count_q;
	logic [SEQ_W-1:0]  next_q, oldest_q;
	logic [LEN_W-1:0]  push_cnt_q;
	logic              push_ovf_q;
	logic              op_push_q;
	logic [SEQ_W-1:0]  seq_in_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  div_rem_q;
	logic [SEQ_W-1:0]  div_dvd_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [SLOT_W-1:0] idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  ci_q;
	logic              rd_v_s1;
	logic [BYTE_W-1:0] addr_s1;
	logic [7:0]        stg_rd_s1;
	logic [LEN_W-1:0]  gi_q;
	logic [7:0]        rec_rd_q;
	logic [LEN_W-1:0]  len_rd_q;
	logic [2:0]        o_status_q;
	logic [SEQ_W-1:0]  o_seq_q;
	logic [7:0]        o_byte_q;
	logic [LEN_W-1:0]  o_len_q;
	logic              o_last_q;

	logic              s_acc, m_acc;
	logic [1:0]        cmd;
	logic [SIZE_W-1:0] size_use;
	logic [CNT_W-1:0]  cnt_use;
	logic [SEQ_W-1:0]  held;
	logic [CNT_W:0]    div_t;
	logic              div_ge;
	logic [CNT_W-1:0]  div_nrem;
	logic [SEQ_W-1:0]  nxt_inc, nxt_diff;
	logic [LEN_W-1:0]  glen;
	logic              stg_we, stg_re, len_we, len_re, rec_re;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign m_acc    = m_tvalid && m_tready;
	assign cmd      = s_tuser[1:0];

	// clamped register values in use
	always_comb begin
		if (slot_size_q == '0) size_use = SIZE_W'(1);
		else if (slot_size_q > SIZE_W'(MAX_SLOT_BYTES)) size_use = SIZE_W'(MAX_SLOT_BYTES);
		else size_use = slot_size_q;
		if (slot_count_q == '0) cnt_use = CNT_W'(1);
		else if (slot_count_q > CNT_W'(MAX_SLOTS)) cnt_use = CNT_W'(MAX_SLOTS);
		else cnt_use = slot_count_q;
	end

	// shared modulo step: shift in one dividend bit, subtract when it fits
	assign div_t    = {div_rem_q, div_dvd_q[SEQ_W-1]};
	assign div_ge   = (div_t >= {1'b0, cnt_use});
	assign div_nrem = div_ge ? CNT_W'(div_t - {1'b0, cnt_use}) : div_t[CNT_W-1:0];

	// window slide after a stored record
	assign nxt_inc  = next_q + SEQ_W'(1);
	assign nxt_diff = nxt_inc - oldest_q;

	// fetched length clamped to a slot
	assign glen = (len_rd_q > LEN_W'(MAX_SLOT_BYTES)) ? LEN_W'(MAX_SLOT_BYTES) : len_rd_q;

	// memory strobes
	assign stg_we = s_acc && (cmd == CMD_PUSH) && s_tuser[2] && (push_cnt_q < size_use);
	assign stg_re = (state_q == S_PCOPY) && (ci_q < len_q);
	assign len_we = (state_q == S_PFIN);
	assign len_re = (state_q == S_GLEN);
	assign rec_re = (state_q == S_GRD);

	always_ff @(posedge clk) begin
		if (stg_we) staging_mem[push_cnt_q[BYTE_W-1:0]] <= s_tdata[7:0];
		if (stg_re) begin
			stg_rd_s1 <= staging_mem[ci_q[BYTE_W-1:0]];
			addr_s1   <= ci_q[BYTE_W-1:0];
		end
		if (rd_v_s1) record_mem[{idx_q, addr_s1}] <= stg_rd_s1;
		if (rec_re) rec_rd_q <= record_mem[{idx_q, gi_q[BYTE_W-1:0]}];
		if (len_we) length_mem[idx_q] <= len_q;
		if (len_re) len_rd_q <= length_mem[idx_q];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_q  <= SIZE_W'(MAX_SLOT_BYTES);
			slot_count_q <= CNT_W'(MAX_SLOTS);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SLOT_SIZE:  slot_size_q  <= wr_data[SIZE_W-1:0];
				REG_SLOT_COUNT: slot_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			next_q     <= '0;
			oldest_q   <= '0;
			push_cnt_q <= '0;
			push_ovf_q <= 1'b0;
			rd_v_s1    <= 1'b0;
			op_push_q  <= 1'b0;
			seq_in_q   <= '0;
			cap_q      <= '0;
			div_rem_q  <= '0;
			div_dvd_q  <= '0;
			div_cnt_q  <= '0;
			idx_q      <= '0;
			len_q      <= '0;
			ci_q       <= '0;
			gi_q       <= '0;
			o_status_q <= ST_OK;
			o_seq_q    <= '0;
			o_byte_q   <= '0;
			o_len_q    <= '0;
			o_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						seq_in_q <= s_tdata[71:8];
						cap_q    <= s_tdata[87:72];
						o_status_q <= ST_OK;
						o_seq_q    <= '0;
						o_byte_q   <= '0;
						o_len_q    <= '0;
						o_last_q   <= 1'b1;
						unique case (cmd)
							CMD_PUSH: begin
								if (s_tuser[2]) begin
									if (push_cnt_q < size_use) push_cnt_q <= push_cnt_q + LEN_W'(1);
									else push_ovf_q <= 1'b1;
								end
								if (s_tlast) state_q <= S_PDEC;
							end
							CMD_GET:    state_q <= S_GCHK;
							CMD_RESUME: state_q <= S_RES;
							default: ;
						endcase
					end
				end
				S_PDEC: begin
					if (push_ovf_q || (push_cnt_q > size_use)) begin
						push_cnt_q <= '0;
						push_ovf_q <= 1'b0;
						o_status_q <= ST_TOO_LARGE;
						state_q    <= S_OUT;
					end else begin
						len_q     <= push_cnt_q;
						op_push_q <= 1'b1;
						div_rem_q <= '0;
						div_dvd_q <= next_q;
						div_cnt_q <= '0;
						state_q   <= S_MOD;
					end
				end
				S_MOD: begin
					div_rem_q <= div_nrem;
					div_dvd_q <= {div_dvd_q[SEQ_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q + DIV_CW'(1);
					if (div_cnt_q == DIV_CW'(SEQ_W-1)) begin
						idx_q <= div_nrem[SLOT_W-1:0];
						ci_q  <= '0;
						state_q <= op_push_q ? S_PCOPY : S_GLEN;
					end
				end
				S_PCOPY: begin
					// staging read is registered, record write follows in the next cycle
					rd_v_s1 <= stg_re;
					if (stg_re) ci_q <= ci_q + LEN_W'(1);
					else if (!rd_v_s1) state_q <= S_PFIN;
				end
				S_PFIN: begin
					next_q <= nxt_inc;
					if (nxt_diff > SEQ_W'(cnt_use)) oldest_q <= nxt_inc - SEQ_W'(cnt_use);
					push_cnt_q <= '0;
					push_ovf_q <= 1'b0;
					o_seq_q    <= next_q;
					o_len_q    <= len_q;
					state_q    <= S_OUT;
				end
				S_GCHK: begin
					if (seq_in_q >= next_q) begin
						o_status_q <= ST_NOT_YET;
						state_q    <= S_OUT;
					end else if (seq_in_q < oldest_q) begin
						o_status_q <= ST_EVICTED;
						state_q    <= S_OUT;
					end else begin
						op_push_q <= 1'b0;
						div_rem_q <= '0;
						div_dvd_q <= seq_in_q;
						div_cnt_q <= '0;
						state_q   <= S_MOD;
					end
				end
				S_GLEN: state_q <= S_GCAP;
				S_GCAP: begin
					if (CAP_W'(glen) > cap_q) begin
						o_status_q <= ST_TOO_LARGE;
						state_q    <= S_OUT;
					end else if (glen == '0) begin
						state_q <= S_OUT;
					end else begin
						len_q   <= glen;
						gi_q    <= '0;
						state_q <= S_GRD;
					end
				end
				S_GRD: state_q <= S_GWR;
				S_GWR: begin
					o_byte_q <= rec_rd_q;
					o_len_q  <= len_q;
					o_last_q <= ((gi_q + LEN_W'(1)) == len_q);
					state_q  <= S_OUT;
				end
				S_RES: begin
					if (next_q != oldest_q) begin
						o_status_q <= ST_NOT_EMPTY;
					end else begin
						next_q   <= seq_in_q;
						oldest_q <= seq_in_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_acc) begin
						if (o_last_q) begin
							state_q <= S_IDLE;
						end else begin
							gi_q    <= gi_q + LEN_W'(1);
							state_q <= S_GRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload; counters hold still while a result waits
	assign held    = next_q - oldest_q;
	assign m_tuser = o_status_q;
	assign m_tlast = o_last_q;
	assign m_tdata = {(OUT_W-217)'(0), oldest_q, next_q, (held == SEQ_W'(cnt_use)),
		held[CNT_W-1:0], o_len_q, o_byte_q, o_seq_q};

	// checks
	`SIRB_NEVER(a_ready_while_out, clk, arst_n, s_tready && m_tvalid, "ready with result pending")
	`SIRB_ASSERT(a_get_busy, clk, arst_n, s_acc && (cmd == CMD_GET) |=> !s_tready, "get not busy")
	`SIRB_ASSERT(a_more_bytes, clk, arst_n, m_acc && !m_tlast |=> !s_tready && !m_tvalid, "byte run cut")
endmodule

// ===== tb/sirb_checker.sv =====
// result checker for the sequence indexed retransmit buffer testbench
// watches the stream and write ports, predicts every result and compares them
// depends on sirb_pkg
`timescale 1ns / 100ps
module sirb_checker
	import sirb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [CNT_W-1:0] wr_data,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // data_byte, seq_number, out_capacity
	input  logic [2:0]       s_tuser,   // cmd, byte_valid
	input  logic             s_tlast,   // last_byte
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // seq_out, data_byte_out, record_length, held_count,
	                                    // full_res, next_seq_out, oldest_seq_out, zero fill
	input  logic [2:0]       m_tuser,   // status
	input  logic             m_tlast,   // last
	output int               fail_count,
	output int               pending,
	output logic [SEQ_W-1:0] win_next,
	output logic [SEQ_W-1:0] win_oldest
);
	typedef struct {
		logic [2:0]       status;
		logic [SEQ_W-1:0] seq;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             fin;
		logic [CNT_W-1:0] held;
		logic             full;
		logic [SEQ_W-1:0] nxt;
		logic [SEQ_W-1:0] old;
	} buf_result_t;

	buf_result_t      expected_q[$];
	logic [7:0]       record_mem[MAX_SLOTS*MAX_SLOT_BYTES];
	logic [LEN_W-1:0] length_mem[MAX_SLOTS];
	logic [7:0]       staging[MAX_SLOT_BYTES];
	int               stage_cnt;
	logic             stage_ovf;
	logic [SIZE_W-1:0] size_reg;
	logic [CNT_W-1:0] count_reg;

	function automatic int clamp(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// queue one expected result, status fields taken from the counters after the item
	task automatic add_result(logic [2:0] st, logic [SEQ_W-1:0] sq, logic [7:0] b,
		int len, logic fin);
		buf_result_t r;
		logic [SEQ_W-1:0] held;
		held     = win_next - win_oldest;
		r.status = st;
		r.seq    = sq;
		r.data   = b;
		r.len    = len[LEN_W-1:0];
		r.fin    = fin;
		r.held   = held[CNT_W-1:0];
		r.full   = (held == SEQ_W'(clamp(int'(count_reg), MAX_SLOTS)));
		r.nxt    = win_next;
		r.old    = win_oldest;
		expected_q.push_back(r);
	endtask

	// work out the results of one accepted input transaction
	task automatic predict_item(logic [1:0] cmd, logic bv, logic lb, logic [7:0] b,
		logic [SEQ_W-1:0] sq, logic [CAP_W-1:0] cap);
		int limit;
		int cnt;
		int idx;
		int len;
		limit = clamp(int'(size_reg), MAX_SLOT_BYTES);
		cnt   = clamp(int'(count_reg), MAX_SLOTS);
		case (cmd)
			CMD_PUSH: begin
				if (bv) begin
					if (stage_cnt < limit) begin
						staging[stage_cnt] = b;
						stage_cnt++;
					end else begin
						stage_ovf = 1'b1;
					end
				end
				if (lb) begin
					if (stage_ovf || stage_cnt > limit) begin
						add_result(ST_TOO_LARGE, '0, '0, 0, 1'b1);
					end else begin
						idx = int'(win_next % SEQ_W'(cnt));
						for (int i = 0; i < stage_cnt; i++)
							record_mem[idx*MAX_SLOT_BYTES+i] = staging[i];
						length_mem[idx] = stage_cnt[LEN_W-1:0];
						win_next = win_next + 1;
						if (win_next - win_oldest > SEQ_W'(cnt))
							win_oldest = win_next - SEQ_W'(cnt);
						add_result(ST_OK, win_next - 1, '0, stage_cnt, 1'b1);
					end
					stage_cnt = 0;
					stage_ovf = 1'b0;
				end
			end
			CMD_GET: begin
				if (sq >= win_next) begin
					add_result(ST_NOT_YET, '0, '0, 0, 1'b1);
				end else if (sq < win_oldest) begin
					add_result(ST_EVICTED, '0, '0, 0, 1'b1);
				end else begin
					idx = int'(sq % SEQ_W'(cnt));
					len = clamp(int'(length_mem[idx]) + 1, MAX_SLOT_BYTES + 1) - 1;
					if (len > int'(cap))
						add_result(ST_TOO_LARGE, '0, '0, 0, 1'b1);
					else if (len == 0)
						add_result(ST_OK, '0, '0, 0, 1'b1);
					else
						for (int i = 0; i < len; i++)
							add_result(ST_OK, '0, record_mem[idx*MAX_SLOT_BYTES+i], len,
								i == len - 1);
				end
			end
			CMD_RESUME: begin
				if (win_next != win_oldest) begin
					add_result(ST_NOT_EMPTY, '0, '0, 0, 1'b1);
				end else begin
					win_next   = sq;
					win_oldest = sq;
					add_result(ST_OK, '0, '0, 0, 1'b1);
				end
			end
			default: ;
		endcase
	endtask

	// compare one result transaction with the oldest expectation
	task automatic compare_result();
		buf_result_t e;
		if (expected_q.size() == 0) begin
			$error("unexpected result transaction, status %0d", m_tuser);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		if (m_tuser !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, m_tuser);
			fail_count++;
		end
		if (m_tdata[63:0] !== e.seq) begin
			$error("seq_out: expected %0h, got %0h", e.seq, m_tdata[63:0]);
			fail_count++;
		end
		if (m_tdata[71:64] !== e.data) begin
			$error("data_byte_out: expected %0h, got %0h", e.data, m_tdata[71:64]);
			fail_count++;
		end
		if (m_tdata[78:72] !== e.len) begin
			$error("record_length: expected %0d, got %0d", e.len, m_tdata[78:72]);
			fail_count++;
		end
		if (m_tlast !== e.fin) begin
			$error("last: expected %0d, got %0d", e.fin, m_tlast);
			fail_count++;
		end
		if (m_tdata[87:79] !== e.held) begin
			$error("held_count: expected %0d, got %0d", e.held, m_tdata[87:79]);
			fail_count++;
		end
		if (m_tdata[88] !== e.full) begin
			$error("full_res: expected %0d, got %0d", e.full, m_tdata[88]);
			fail_count++;
		end
		if (m_tdata[152:89] !== e.nxt) begin
			$error("next_seq_out: expected %0h, got %0h", e.nxt, m_tdata[152:89]);
			fail_count++;
		end
		if (m_tdata[216:153] !== e.old) begin
			$error("oldest_seq_out: expected %0h, got %0h", e.old, m_tdata[216:153]);
			fail_count++;
		end
	endtask

	// compare first, then register writes and new input transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			fail_count = 0;
			pending    = 0;
			win_next   = '0;
			win_oldest = '0;
			stage_cnt  = 0;
			stage_ovf  = 1'b0;
			size_reg   = SIZE_W'(MAX_SLOT_BYTES);
			count_reg  = CNT_W'(MAX_SLOTS);
			foreach (length_mem[i]) length_mem[i] = '0;
			foreach (record_mem[i]) record_mem[i] = '0;
		end else begin
			if (m_tvalid && m_tready)
				compare_result();
			if (wr_en) begin
				if (wr_index == REG_SLOT_SIZE)
					size_reg = wr_data[SIZE_W-1:0];
				else
					count_reg = wr_data;
			end
			if (s_tvalid && s_tready)
				predict_item(s_tuser[1:0], s_tuser[2], s_tlast, s_tdata[7:0],
					s_tdata[71:8], s_tdata[87:72]);
			pending = expected_q.size();
		end
	end
endmodule

// ===== tb/sequence_indexed_retransmit_buffer_tb.sv =====
// testbench top for the sequence indexed retransmit buffer
// drives directed and random stream traffic and register writes, gives the verdict
// depends on sirb_pkg, sirb_checker and the block itself
`timescale 1ns / 100ps
module sequence_indexed_retransmit_buffer_tb;
	import sirb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 200;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic             wr_index;
	logic [CNT_W-1:0] wr_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [2:0]       s_tuser;
	logic             s_tlast;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [2:0]       m_tuser;
	logic             m_tlast;
	int               fail_count;
	int               pending;
	logic [SEQ_W-1:0] win_next;
	logic [SEQ_W-1:0] win_oldest;

	int               send_idle_pct;
	int               recv_idle_pct;
	int               cycles = 0;
	int               cur_size;
	logic [SEQ_W-1:0] safe_seq;

	sequence_indexed_retransmit_buffer u_dut (.*);

	sirb_checker u_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sequence_indexed_retransmit_buffer: mismatch");
			$finish;
		end
	end

	// one input transaction, with an optional gap before it
	task automatic send(logic [1:0] cmd, logic [7:0] b, logic bv, logic lb,
		logic [SEQ_W-1:0] sq, logic [CAP_W-1:0] cap);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tdata  <= {cap, sq, b};
		s_tuser  <= {bv, cmd};
		s_tlast  <= lb;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// sequence inside the part of the window written under the current slot count
	function automatic logic [SEQ_W-1:0] pick_get_seq();
		logic [SEQ_W-1:0] lo;
		lo = (win_oldest > safe_seq) ? win_oldest : safe_seq;
		if (lo < win_next)
			return lo + ({$urandom, $urandom} % (win_next - lo));
		return win_next;
	endfunction

	// whole record of len bytes, last flag on the final byte
	task automatic push_record(int len, output int items);
		items = 0;
		if (len == 0) begin
			send(CMD_PUSH, 8'($urandom), 1'b0, 1'b1, 64'($urandom), 16'($urandom));
			items = 1;
			return;
		end
		for (int i = 0; i < len; i++) begin
			// occasional filler and interleaved commands inside the record
			if ($urandom_range(19) == 0) begin
				send(CMD_PUSH, 8'($urandom), 1'b0, 1'b0, 64'($urandom), 16'($urandom));
				items++;
			end
			if ($urandom_range(29) == 0) begin
				send(CMD_GET, 8'($urandom), 1'($urandom), 1'($urandom),
					pick_get_seq(), 16'($urandom_range(80)));
				items++;
			end
			send(CMD_PUSH, 8'($urandom), 1'b1, i == len - 1, 64'($urandom),
				16'($urandom));
			items++;
		end
	endtask

	// register write while the block is idle
	task automatic write_reg(logic idx, int value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CNT_W'(value);
		@(posedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int size, int count);
		wait_idle();
		write_reg(REG_SLOT_SIZE, size);
		write_reg(REG_SLOT_COUNT, count);
		cur_size = (size % 128 < 1) ? 1 : (size % 128 > 64) ? 64 : size % 128;
		safe_seq = win_next;
		@(posedge clk);
	endtask

	// random traffic, mostly well formed records and gets inside the window
	task automatic random_phase(int target);
		int items;
		int n;
		int r;
		int len;
		logic [SEQ_W-1:0] sq;
		items = 0;
		while (items < target) begin
			r = $urandom_range(99);
			if (r < 50) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(cur_size + 3);
				else
					len = $urandom_range(cur_size < 8 ? cur_size : 8);
				push_record(len, n);
				items += n;
			end else if (r < 85) begin
				case ($urandom_range(4))
					0: sq = {$urandom, $urandom};
					1: sq = win_next + $urandom_range(2);
					2: sq = win_oldest - 1;
					default: sq = pick_get_seq();
				endcase
				send(CMD_GET, 8'($urandom), 1'($urandom), 1'($urandom), sq,
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(66)));
				items++;
			end else if (r < 93) begin
				send(CMD_RESUME, 8'($urandom), 1'($urandom), 1'($urandom),
					{$urandom, $urandom}, 16'($urandom));
				items++;
			end else begin
				send(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom),
					{$urandom, $urandom}, 16'($urandom));
				items++;
			end
		end
	endtask

	initial begin
		int n;
		send_idle_pct = 17;
		recv_idle_pct = 60;
		cur_size      = 64;
		safe_seq      = '0;
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = 1'b0;
		wr_data  = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty buffer, counter wrap, extreme lengths and capacities
		configure(64, 3);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'd0, 16'hFFFF);
		send(CMD_RESUME, 8'hFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0);
		safe_seq = 64'hFFFF_FFFF_FFFF_FFFE;
		send(CMD_PUSH, 8'h00, 1'b0, 1'b1, '0, '0);
		for (int i = 0; i < 64; i++)
			send(CMD_PUSH, (i % 2) ? 8'hFF : 8'h00, 1'b1, i == 63, '1, '1);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd64);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd63);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0);
		send(CMD_RESUME, 8'h00, 1'b0, 1'b0, 64'd5, 16'd0);
		send(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, '1, '1);
		push_record(2, n);
		push_record(1, n);
		push_record(3, n);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'd1, 16'hFFFF);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send(CMD_GET, 8'h00, 1'b0, 1'b0, 64'd3, 16'd0);

		// random phases under different window and size settings
		configure(0, 0);
		random_phase(22);
		send_idle_pct = 60;
		recv_idle_pct = 17;
		configure(127, 511);
		random_phase(22);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(9, 5);
		// record one byte over the slot size
		push_record(10, n);
		random_phase(22);
		configure(64, 256);
		random_phase(22);

		wait_idle();
		if (fail_count == 0)
			$display("sequence_indexed_retransmit_buffer: match");
		else
			$display("sequence_indexed_retransmit_buffer: mismatch");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/sirb_pkg.sv
sv/sequence_indexed_retransmit_buffer.sv
tb/sirb_checker.sv
tb/sequence_indexed_retransmit_buffer_tb.sv
